>>> hdl/phr_pkg.sv
// Shared types, constants and the hue-to-ratio function of the palette hue replace block.
`timescale 1ns / 1ps

package phr_pkg;

	localparam int CH_W     = 8;  // one color channel or palette index
	localparam int NUM_W    = 6;  // numerator of the hue ratio, never above 42
	localparam int DEN_W    = 7;  // denominator of the hue ratio, 43 to 85
	localparam int PROD_W   = CH_W + NUM_W;
	localparam int DIV_BITS = 2;  // quotient bits resolved per divider stage

	localparam int PALETTE_ENTRIES = 256;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_NEW_HUE     = 2'd0;
	localparam logic [1:0] REG_RANGE_FIRST = 2'd1;
	localparam logic [1:0] REG_RANGE_LAST  = 2'd2;

	// Sextant boundaries on the 0..255 hue circle.
	localparam logic [CH_W-1:0] HUE_RY_END = 8'd42;
	localparam logic [CH_W-1:0] HUE_THIRD  = 8'd85;
	localparam logic [CH_W-1:0] HUE_GC_END = 8'd127;
	localparam logic [CH_W-1:0] HUE_2THIRD = 8'd170;
	localparam logic [CH_W-1:0] HUE_BM_END = 8'd212;
	localparam logic [CH_W-1:0] HUE_FULL   = 8'd255;

	typedef enum logic [2:0] {
		SEXT_R_TO_Y,
		SEXT_Y_TO_G,
		SEXT_G_TO_C,
		SEXT_C_TO_B,
		SEXT_B_TO_M,
		SEXT_M_TO_R
	} phr_sext_t;

	typedef struct packed {
		phr_sext_t        sext;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} phr_ratio_t;

	typedef struct packed {
		logic            hit;
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] mx;
		logic [CH_W-1:0] mn;
	} phr_pix_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [CH_W-1:0]  quot;
		logic [CH_W-1:0]  low;   // dividend bits not yet brought down, MSB first
	} phr_div_t;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} phr_rgb_t;

	// Picks the sextant and the exact fraction num/den for the mixed channel.
	function automatic phr_ratio_t phr_hue_ratio(input logic [CH_W-1:0] hue);
		phr_ratio_t r;
		r.sext = SEXT_R_TO_Y;
		r.num  = '0;
		r.den  = DEN_W'(HUE_THIRD);
		if (hue <= HUE_RY_END) begin
			r.sext = SEXT_R_TO_Y;
			r.num  = NUM_W'(hue);
			r.den  = DEN_W'(HUE_THIRD - hue);
		end else if (hue <= HUE_THIRD) begin
			r.sext = SEXT_Y_TO_G;
			r.num  = NUM_W'(HUE_THIRD - hue);
			r.den  = DEN_W'(hue);
		end else if (hue <= HUE_GC_END) begin
			r.sext = SEXT_G_TO_C;
			r.num  = NUM_W'(hue - HUE_THIRD);
			r.den  = DEN_W'(HUE_2THIRD - hue);
		end else if (hue <= HUE_2THIRD) begin
			r.sext = SEXT_C_TO_B;
			r.num  = NUM_W'(HUE_2THIRD - hue);
			r.den  = DEN_W'(hue - HUE_THIRD);
		end else if (hue <= HUE_BM_END) begin
			r.sext = SEXT_B_TO_M;
			r.num  = NUM_W'(hue - HUE_2THIRD);
			r.den  = DEN_W'(HUE_FULL - hue);
		end else begin
			r.sext = SEXT_M_TO_R;
			r.num  = NUM_W'(HUE_FULL - hue);
			r.den  = DEN_W'(hue - HUE_2THIRD);
		end
		return r;
	endfunction

endpackage

>>> hdl/phr_div_step.sv
// Two restoring-division steps: brings down two dividend bits and yields two quotient bits.
`timescale 1ns / 1ps

module phr_div_step
	import phr_pkg::*;
(
	input  logic [DEN_W-1:0]    rem_in,
	input  logic [DIV_BITS-1:0] bits_in,
	input  logic [DEN_W-1:0]    den,
	output logic [DEN_W-1:0]    rem_out,
	output logic [DIV_BITS-1:0] quot_out
);

	always_comb begin
		logic [DEN_W:0]   trial;
		logic [DEN_W-1:0] rem;
		rem      = rem_in;
		quot_out = '0;
		for (int i = DIV_BITS - 1; i >= 0; i--) begin
			trial = {rem, bits_in[i]};
			if (trial >= {1'b0, den}) begin
				trial       = trial - {1'b0, den};
				quot_out[i] = 1'b1;
			end
			// The remainder stays below den, so it fits back into DEN_W bits.
			rem = trial[DEN_W-1:0];
		end
		rem_out = rem;
	end

endmodule

>>> hdl/palette_hue_replace.sv
// Top level of the palette hue replace block: register port and seven-stage recolor pipeline.
`timescale 1ns / 1ps

//  Channel  Side    Handshake                  Payload
//  config   slave   APB write/read, pready=1   new_hue @0x0, range_first @0x4, range_last @0x8
//  s_*      slave   tvalid/tready              tdata = entry_index, in_red, in_green, in_blue
//  m_*      master  tvalid/tready              tdata = out_red, out_green, out_blue
//
//  Each accepted beat moves through every stage to its output beat; one beat enters per cycle
//  while m_tready is high; four two-bit divider stages give the eight quotient bits.
//  The asynchronous reset clears the valid bits and the registers (new_hue 0,
//  range_first 0, range_last 255); payload registers are not reset.
//  A stalled output holds its beat; each stage advances when empty or when the stage
//  after it advances, so bubbles close up and s_tready stays high while m_tready is high.

module palette_hue_replace
	import phr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,

	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [31:0]       s_tdata,   // entry_index[7:0], in_red[15:8], in_green[23:16], in_blue[31:24]

	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata    // out_red[7:0], out_green[15:8], out_blue[23:16]
);

	// ------------------------------------------------------------------
	// Configuration registers. Writes land in the access phase; the hue
	// is turned into its sextant and fraction in the next cycle, which is
	// in time for an item accepted after the write to use it in stage 2.
	// ------------------------------------------------------------------
	logic [CH_W-1:0] new_hue_q;
	logic [CH_W-1:0] range_first_q;
	logic [CH_W-1:0] range_last_q;
	phr_ratio_t      ratio_q;
	logic            cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			new_hue_q     <= '0;
			range_first_q <= '0;
			range_last_q  <= HUE_FULL;
			ratio_q       <= phr_hue_ratio('0);
		end else begin
			if (cfg_wr) begin
				case (paddr[3:2])
					REG_NEW_HUE:     new_hue_q     <= pwdata[CH_W-1:0];
					REG_RANGE_FIRST: range_first_q <= pwdata[CH_W-1:0];
					REG_RANGE_LAST:  range_last_q  <= pwdata[CH_W-1:0];
					default:         ;
				endcase
			end
			ratio_q <= phr_hue_ratio(new_hue_q);
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NEW_HUE:     prdata = DATA_W'(new_hue_q);
			REG_RANGE_FIRST: prdata = DATA_W'(range_first_q);
			REG_RANGE_LAST:  prdata = DATA_W'(range_last_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Pipeline flow control. A stage loads when it is empty or when its
	// content moves on in the same cycle.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6, adv_s7;

	assign adv_s7 = !vld_s7 || m_tready;
	assign adv_s6 = !vld_s6 || adv_s7;
	assign adv_s5 = !vld_s5 || adv_s6;
	assign adv_s4 = !vld_s4 || adv_s5;
	assign adv_s3 = !vld_s3 || adv_s4;
	assign adv_s2 = !vld_s2 || adv_s3;
	assign adv_s1 = !vld_s1 || adv_s2;

	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (adv_s1) vld_s1 <= s_tvalid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (adv_s3) vld_s3 <= vld_s2;
			if (adv_s4) vld_s4 <= vld_s3;
			if (adv_s5) vld_s5 <= vld_s4;
			if (adv_s6) vld_s6 <= vld_s5;
			if (adv_s7) vld_s7 <= vld_s6;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: range check, channel maximum and minimum.
	// ------------------------------------------------------------------
	logic [CH_W-1:0] in_idx, in_r, in_g, in_b;
	logic [CH_W-1:0] rg_max, rg_min;
	phr_pix_t        pix_d1;

	assign in_idx = s_tdata[7:0];
	assign in_r   = s_tdata[15:8];
	assign in_g   = s_tdata[23:16];
	assign in_b   = s_tdata[31:24];

	always_comb begin
		rg_max       = (in_r > in_g) ? in_r : in_g;
		rg_min       = (in_r < in_g) ? in_r : in_g;
		pix_d1.hit   = (in_idx >= range_first_q) && (in_idx <= range_last_q) &&
		               ((CH_W + 1)'(in_idx) < (CH_W + 1)'(PALETTE_ENTRIES));
		pix_d1.red   = in_r;
		pix_d1.green = in_g;
		pix_d1.blue  = in_b;
		pix_d1.mx    = (in_b > rg_max) ? in_b : rg_max;
		pix_d1.mn    = (in_b < rg_min) ? in_b : rg_min;
	end

	phr_pix_t pix_s1, pix_s2, pix_s3, pix_s4, pix_s5, pix_s6;

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) pix_s1 <= pix_d1;
	end

	// ------------------------------------------------------------------
	// Stage 2: spread times numerator. The product is below 256 * den,
	// so its top bits already form a remainder smaller than den and the
	// low byte is what the divider brings down two bits at a time.
	// ------------------------------------------------------------------
	logic [PROD_W-1:0] prod_d2;
	phr_div_t          div_s2, div_s3, div_s4, div_s5, div_s6;

	assign prod_d2 = PROD_W'(pix_s1.mx - pix_s1.mn) * PROD_W'(ratio_q.num);

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			pix_s2      <= pix_s1;
			div_s2.rem  <= DEN_W'(prod_d2 >> CH_W);
			div_s2.quot <= '0;
			div_s2.low  <= prod_d2[CH_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 to 6: restoring division by den, two quotient bits each.
	// ------------------------------------------------------------------
	logic [DEN_W-1:0]    rem_d3, rem_d4, rem_d5, rem_d6;
	logic [DIV_BITS-1:0] qb_d3, qb_d4, qb_d5, qb_d6;

	phr_div_step u_step_s3 (
		.rem_in  (div_s2.rem),
		.bits_in (div_s2.low[CH_W-1 -: DIV_BITS]),
		.den     (ratio_q.den),
		.rem_out (rem_d3),
		.quot_out(qb_d3)
	);

	phr_div_step u_step_s4 (
		.rem_in  (div_s3.rem),
		.bits_in (div_s3.low[CH_W-1 -: DIV_BITS]),
		.den     (ratio_q.den),
		.rem_out (rem_d4),
		.quot_out(qb_d4)
	);

	phr_div_step u_step_s5 (
		.rem_in  (div_s4.rem),
		.bits_in (div_s4.low[CH_W-1 -: DIV_BITS]),
		.den     (ratio_q.den),
		.rem_out (rem_d5),
		.quot_out(qb_d5)
	);

	phr_div_step u_step_s6 (
		.rem_in  (div_s5.rem),
		.bits_in (div_s5.low[CH_W-1 -: DIV_BITS]),
		.den     (ratio_q.den),
		.rem_out (rem_d6),
		.quot_out(qb_d6)
	);

	always_ff @(posedge clk) begin
		if (adv_s3 && vld_s2) begin
			pix_s3      <= pix_s2;
			div_s3.rem  <= rem_d3;
			div_s3.quot <= {div_s2.quot[CH_W-DIV_BITS-1:0], qb_d3};
			div_s3.low  <= {div_s2.low[CH_W-DIV_BITS-1:0], DIV_BITS'(0)};
		end
		if (adv_s4 && vld_s3) begin
			pix_s4      <= pix_s3;
			div_s4.rem  <= rem_d4;
			div_s4.quot <= {div_s3.quot[CH_W-DIV_BITS-1:0], qb_d4};
			div_s4.low  <= {div_s3.low[CH_W-DIV_BITS-1:0], DIV_BITS'(0)};
		end
		if (adv_s5 && vld_s4) begin
			pix_s5      <= pix_s4;
			div_s5.rem  <= rem_d5;
			div_s5.quot <= {div_s4.quot[CH_W-DIV_BITS-1:0], qb_d5};
			div_s5.low  <= {div_s4.low[CH_W-DIV_BITS-1:0], DIV_BITS'(0)};
		end
		if (adv_s6 && vld_s5) begin
			pix_s6      <= pix_s5;
			div_s6.rem  <= rem_d6;
			div_s6.quot <= {div_s5.quot[CH_W-DIV_BITS-1:0], qb_d6};
			div_s6.low  <= {div_s5.low[CH_W-DIV_BITS-1:0], DIV_BITS'(0)};
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: place max, min and the mixed channel by sextant, or pass
	// the entry through. The mixed channel never exceeds the maximum, so
	// the add cannot overflow. A black entry has zero spread and stays black.
	// ------------------------------------------------------------------
	logic [CH_W-1:0] mid_d7;
	phr_rgb_t        rgb_d7, rgb_s7;

	assign mid_d7 = pix_s6.mn + div_s6.quot;

	always_comb begin
		rgb_d7.red   = pix_s6.red;
		rgb_d7.green = pix_s6.green;
		rgb_d7.blue  = pix_s6.blue;
		if (pix_s6.hit) begin
			case (ratio_q.sext)
				SEXT_R_TO_Y: begin
					rgb_d7.red   = pix_s6.mx;
					rgb_d7.green = mid_d7;
					rgb_d7.blue  = pix_s6.mn;
				end
				SEXT_Y_TO_G: begin
					rgb_d7.red   = mid_d7;
					rgb_d7.green = pix_s6.mx;
					rgb_d7.blue  = pix_s6.mn;
				end
				SEXT_G_TO_C: begin
					rgb_d7.red   = pix_s6.mn;
					rgb_d7.green = pix_s6.mx;
					rgb_d7.blue  = mid_d7;
				end
				SEXT_C_TO_B: begin
					rgb_d7.red   = pix_s6.mn;
					rgb_d7.green = mid_d7;
					rgb_d7.blue  = pix_s6.mx;
				end
				SEXT_B_TO_M: begin
					rgb_d7.red   = mid_d7;
					rgb_d7.green = pix_s6.mn;
					rgb_d7.blue  = pix_s6.mx;
				end
				SEXT_M_TO_R: begin
					rgb_d7.red   = pix_s6.mx;
					rgb_d7.green = pix_s6.mn;
					rgb_d7.blue  = mid_d7;
				end
				default: begin
					rgb_d7.red   = pix_s6.red;
					rgb_d7.green = pix_s6.green;
					rgb_d7.blue  = pix_s6.blue;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s7 && vld_s6) rgb_s7 <= rgb_d7;
	end

	assign m_tvalid = vld_s7;
	assign m_tdata  = rgb_s7;

endmodule

>>> hdl/phr_checker.sv
// Port-level checks for the palette hue replace block and the bind that attaches them.
`timescale 1ns / 1ps

module phr_checker
	import phr_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [ADDR_W-1:0] paddr,
	input logic [DATA_W-1:0] pwdata,
	input logic [DATA_W-1:0] prdata,
	input logic              pready,
	input logic              s_tready,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [23:0]       m_tdata
);

	// A beat that is not taken stays on the bus unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output beat changed or dropped while stalled");

	// With the sink ready the whole pipeline moves, so the input must be open.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input blocked although the output is ready");

	// A register write reads back at the same address in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready &&
		(paddr[3:2] == REG_NEW_HUE || paddr[3:2] == REG_RANGE_FIRST ||
		 paddr[3:2] == REG_RANGE_LAST)
		|=> (paddr[3:2] != $past(paddr[3:2])) ||
		    (prdata == DATA_W'($past(pwdata[CH_W-1:0]))))
		else $error("register read-back differs from the value written");

	// Nothing comes out while reset is held.
	assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind palette_hue_replace phr_checker u_phr_checker (.*);
